// ===== rtl/core/mhs_pkg.sv =====
// Package for the magnetometer heading block: widths, CORDIC constants,
// the arctangent table and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package mhs_pkg;

   localparam int CORDIC_STEPS      = 16;
   localparam int HEADING_FRAC_BITS = 6;
   localparam int ATAN_LEN          = 24;
   localparam int RUN_STEPS         = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam int STEP_W            = (RUN_STEPS > 1) ? $clog2(RUN_STEPS) : 1;
   localparam int ATAN_IDX_W        = 5;

   localparam int ANGLE_FRAC = 16;
   localparam int ROUND_SH   = ANGLE_FRAC - HEADING_FRAC_BITS;
   localparam int XY_W       = 28;
   localparam int ANG_W      = 27;
   localparam int RND_W      = ANG_W - ROUND_SH;
   localparam int HDG_W      = 15;
   localparam int AXIS_W     = 16;
   localparam int TIME_W     = 32;
   localparam int STALE_W    = 16;

   localparam int DRDY_BIT = 0;
   localparam int OVF_BIT  = 3;

   localparam logic [STALE_W-1:0]     STALE_RESET = STALE_W'(1500);
   localparam logic signed [ANG_W-1:0] DEG180_Q   = ANG_W'(180 * 65536);
   localparam logic signed [ANG_W-1:0] DEG360_Q   = ANG_W'(360 * 65536);
   localparam logic signed [ANG_W-1:0] ROUND_HALF = ANG_W'(1 << (ROUND_SH - 1));
   localparam logic [RND_W-1:0]        FULL_TURN  = RND_W'(360 << HEADING_FRAC_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ITER,
      ST_ROUND,
      ST_PUBLISH
   } mhs_state_type;

   // atan(2^-i) in degrees * 65536, rounded to nearest
   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] val;
      unique case (idx)
         5'd0:    val = ANG_W'(2949120);
         5'd1:    val = ANG_W'(1740967);
         5'd2:    val = ANG_W'(919879);
         5'd3:    val = ANG_W'(466945);
         5'd4:    val = ANG_W'(234379);
         5'd5:    val = ANG_W'(117304);
         5'd6:    val = ANG_W'(58666);
         5'd7:    val = ANG_W'(29335);
         5'd8:    val = ANG_W'(14668);
         5'd9:    val = ANG_W'(7334);
         5'd10:   val = ANG_W'(3667);
         5'd11:   val = ANG_W'(1833);
         5'd12:   val = ANG_W'(917);
         5'd13:   val = ANG_W'(458);
         5'd14:   val = ANG_W'(229);
         5'd15:   val = ANG_W'(115);
         5'd16:   val = ANG_W'(57);
         5'd17:   val = ANG_W'(29);
         5'd18:   val = ANG_W'(14);
         5'd19:   val = ANG_W'(7);
         5'd20:   val = ANG_W'(4);
         5'd21:   val = ANG_W'(2);
         5'd22:   val = ANG_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/core/magnetometer_heading_with_staleness.sv =====
// Magnetometer compass heading with staleness tracking: sample checks,
// iterative vectoring CORDIC atan2, held heading state. Uses mhs_pkg.
`timescale 1ns / 1ps

//  channel | ports                  | direction | moves
//  --------+------------------------+-----------+-------------------------------
//  req     | req_valid / req_ready  | in        | one read attempt + timestamp
//  rsp     | rsp_valid / rsp_ready  | out       | taken flag + held heading state
//  csr     | csr_valid / csr_ready  | in        | stale limit in ms
//
//  A good sample runs 16 CORDIC steps on the shared shift/add unit, then a
//  rounding state and a publish state that raises rsp_valid; a rejected
//  sample goes straight to publish. req_ready returns in the same cycle as
//  rsp_valid rises. A pending result does not block acceptance, but publish
//  waits until the result register frees.
//  Reset (synchronous) clears held state to zero and the stale limit to 1500.

module magnetometer_heading_with_staleness (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_read_ok,
   input  logic [7:0]                            req_status_one,
   input  logic [7:0]                            req_x_low,
   input  logic [7:0]                            req_x_high,
   input  logic [7:0]                            req_y_low,
   input  logic [7:0]                            req_y_high,
   input  logic [7:0]                            req_z_low,
   input  logic [7:0]                            req_z_high,
   input  logic [7:0]                            req_status_two,
   input  logic [mhs_pkg::TIME_W-1:0]            req_time_ms,

   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_sample_taken,
   output logic                                  rsp_heading_available,
   output logic [mhs_pkg::HDG_W-1:0]             rsp_heading_deg64,
   output logic signed [mhs_pkg::AXIS_W-1:0]     rsp_axis_x,
   output logic signed [mhs_pkg::AXIS_W-1:0]     rsp_axis_y,
   output logic signed [mhs_pkg::AXIS_W-1:0]     rsp_axis_z,
   output logic [mhs_pkg::TIME_W-1:0]            rsp_update_time_ms,

   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mhs_pkg::STALE_W-1:0]           csr_stale_after_ms
);

   mhs_pkg::mhs_state_type               state_ff, state_in;
   logic [mhs_pkg::STEP_W-1:0]           step_ff, step_in;
   logic signed [mhs_pkg::XY_W-1:0]      x_ff, x_in;
   logic signed [mhs_pkg::XY_W-1:0]      y_ff, y_in;
   logic signed [mhs_pkg::ANG_W-1:0]     ang_ff, ang_in;
   logic [mhs_pkg::RND_W-1:0]            rnd_ff, rnd_in;
   logic                                 take_ff, take_in;
   logic [mhs_pkg::AXIS_W-1:0]           raw_x_ff, raw_x_in;
   logic [mhs_pkg::AXIS_W-1:0]           raw_y_ff, raw_y_in;
   logic [mhs_pkg::AXIS_W-1:0]           raw_z_ff, raw_z_in;
   logic [mhs_pkg::TIME_W-1:0]           now_ff, now_in;

   logic [mhs_pkg::STALE_W-1:0]          stale_ff, stale_in;
   logic                                 avail_ff, avail_in;
   logic [mhs_pkg::TIME_W-1:0]           last_time_ff, last_time_in;
   logic [mhs_pkg::HDG_W-1:0]            held_hdg_ff, held_hdg_in;
   logic [mhs_pkg::AXIS_W-1:0]           held_x_ff, held_x_in;
   logic [mhs_pkg::AXIS_W-1:0]           held_y_ff, held_y_in;
   logic [mhs_pkg::AXIS_W-1:0]           held_z_ff, held_z_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 taken_ff, taken_in;

   logic [mhs_pkg::AXIS_W-1:0]           req_x, req_y, req_z;
   logic                                 req_take;
   logic signed [mhs_pkg::XY_W-1:0]      x_start, y_start;
   logic signed [mhs_pkg::XY_W-1:0]      dx, dy;
   logic                                 y_pos;
   logic signed [mhs_pkg::ANG_W-1:0]     atan_val;
   logic signed [mhs_pkg::ANG_W-1:0]     ang_adj, ang_rnd;
   logic [mhs_pkg::RND_W-1:0]            hdg_wrap;
   logic [mhs_pkg::TIME_W-1:0]           elapsed;
   logic                                 rsp_free;

   assign req_x = {req_x_high, req_x_low};
   assign req_y = {req_y_high, req_y_low};
   assign req_z = {req_z_high, req_z_low};
   assign req_take = req_read_ok & req_status_one[mhs_pkg::DRDY_BIT]
                   & ~req_status_two[mhs_pkg::OVF_BIT]
                   & ~((req_x == '0) && (req_y == '0));

   assign x_start = {{(mhs_pkg::XY_W-mhs_pkg::AXIS_W-8){req_x[mhs_pkg::AXIS_W-1]}}, req_x, 8'h00};
   assign y_start = {{(mhs_pkg::XY_W-mhs_pkg::AXIS_W-8){req_y[mhs_pkg::AXIS_W-1]}}, req_y, 8'h00};

   // shared shift/add unit
   assign dx       = y_ff >>> step_ff;
   assign dy       = x_ff >>> step_ff;
   assign y_pos    = ~y_ff[mhs_pkg::XY_W-1] && (y_ff != '0);
   assign atan_val = mhs_pkg::atan_entry(mhs_pkg::ATAN_IDX_W'(step_ff));

   assign ang_adj  = ang_ff[mhs_pkg::ANG_W-1] ? (ang_ff + mhs_pkg::DEG360_Q) : ang_ff;
   assign ang_rnd  = ang_adj + mhs_pkg::ROUND_HALF;
   assign hdg_wrap = (rnd_ff >= mhs_pkg::FULL_TURN) ? (rnd_ff - mhs_pkg::FULL_TURN) : rnd_ff;
   assign elapsed  = now_ff - last_time_ff;
   assign rsp_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ang_in       = ang_ff;
      rnd_in       = rnd_ff;
      take_in      = take_ff;
      raw_x_in     = raw_x_ff;
      raw_y_in     = raw_y_ff;
      raw_z_in     = raw_z_ff;
      now_in       = now_ff;
      avail_in     = avail_ff;
      last_time_in = last_time_ff;
      held_hdg_in  = held_hdg_ff;
      held_x_in    = held_x_ff;
      held_y_in    = held_y_ff;
      held_z_in    = held_z_ff;
      taken_in     = taken_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      stale_in     = (csr_valid) ? csr_stale_after_ms : stale_ff;

      unique case (state_ff)
         mhs_pkg::ST_IDLE: begin
            if (req_valid) begin
               take_in  = req_take;
               raw_x_in = req_x;
               raw_y_in = req_y;
               raw_z_in = req_z;
               now_in   = req_time_ms;
               step_in  = '0;
               if (x_start[mhs_pkg::XY_W-1]) begin
                  x_in   = -x_start;
                  y_in   = -y_start;
                  ang_in = mhs_pkg::DEG180_Q;
               end else begin
                  x_in   = x_start;
                  y_in   = y_start;
                  ang_in = '0;
               end
               state_in = req_take ? mhs_pkg::ST_ITER : mhs_pkg::ST_PUBLISH;
            end
         end
         mhs_pkg::ST_ITER: begin
            if (y_pos) begin
               x_in   = x_ff + dx;
               y_in   = y_ff - dy;
               ang_in = ang_ff + atan_val;
            end else begin
               x_in   = x_ff - dx;
               y_in   = y_ff + dy;
               ang_in = ang_ff - atan_val;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == mhs_pkg::STEP_W'(mhs_pkg::RUN_STEPS - 1)) begin
               state_in = mhs_pkg::ST_ROUND;
            end
         end
         mhs_pkg::ST_ROUND: begin
            rnd_in   = ang_rnd[mhs_pkg::ANG_W-1:mhs_pkg::ROUND_SH];
            state_in = mhs_pkg::ST_PUBLISH;
         end
         mhs_pkg::ST_PUBLISH: begin
            if (rsp_free) begin
               if (take_ff) begin
                  held_hdg_in  = hdg_wrap[mhs_pkg::HDG_W-1:0];
                  held_x_in    = raw_x_ff;
                  held_y_in    = raw_y_ff;
                  held_z_in    = raw_z_ff;
                  last_time_in = now_ff;
                  avail_in     = 1'b1;
               end else if (avail_ff && (elapsed >
                            {{(mhs_pkg::TIME_W-mhs_pkg::STALE_W){1'b0}}, stale_ff})) begin
                  avail_in = 1'b0;
               end
               taken_in     = take_ff;
               rsp_valid_in = 1'b1;
               state_in     = mhs_pkg::ST_IDLE;
            end
         end
         default: state_in = mhs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhs_pkg::ST_IDLE;
         stale_ff     <= mhs_pkg::STALE_RESET;
         avail_ff     <= 1'b0;
         last_time_ff <= '0;
         held_hdg_ff  <= '0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         held_z_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         taken_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stale_ff     <= stale_in;
         avail_ff     <= avail_in;
         last_time_ff <= last_time_in;
         held_hdg_ff  <= held_hdg_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
         held_z_ff    <= held_z_in;
         rsp_valid_ff <= rsp_valid_in;
         taken_ff     <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      ang_ff   <= ang_in;
      rnd_ff   <= rnd_in;
      take_ff  <= take_in;
      raw_x_ff <= raw_x_in;
      raw_y_ff <= raw_y_in;
      raw_z_ff <= raw_z_in;
      now_ff   <= now_in;
   end

   assign req_ready             = (state_ff == mhs_pkg::ST_IDLE);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_sample_taken      = taken_ff;
   assign rsp_heading_available = avail_ff;
   assign rsp_heading_deg64     = held_hdg_ff;
   assign rsp_axis_x            = held_x_ff;
   assign rsp_axis_y            = held_y_ff;
   assign rsp_axis_z            = held_z_ff;
   assign rsp_update_time_ms    = last_time_ff;

endmodule
